// ===== rtl/core/arp_responder_with_cache_defines.svh =====
// Assertion macros shared by the ARP responder RTL.
`ifndef ARP_RESPONDER_WITH_CACHE_DEFINES_SVH
`define ARP_RESPONDER_WITH_CACHE_DEFINES_SVH
`ifndef SYNTHESIS
`define ARPRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ARPRC_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ARPRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARPRC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/arprc_pkg.sv =====
// Shared types and protocol constants of the ARP responder.
package arprc_pkg;
    localparam int HDR_LEN    = 42;
    localparam int KEEP_FIRST = 12;   // bytes below this are never inspected
    localparam int CNT_W      = 6;

    localparam logic [15:0] ARP_ETHTYPE  = 16'h0806;
    localparam logic [15:0] HTYPE_ETH    = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  HLEN_ETH     = 8'd6;
    localparam logic [7:0]  PLEN_IPV4    = 8'd4;
    localparam logic [15:0] OPER_REQUEST = 16'h0001;
    localparam logic [15:0] OPER_REPLY   = 16'h0002;
    localparam logic [31:0] IP_BCAST     = 32'hFFFF_FFFF;
    localparam logic [47:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;

    localparam logic CMD_RX      = 1'b0;
    localparam logic CMD_LOOKUP  = 1'b1;
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic CFG_LOCAL_MAC = 1'b0;
    localparam logic CFG_LOCAL_IP  = 1'b1;

    // One queued job: a lookup answer, or a reply to be expanded into bytes
    typedef struct packed {
        logic        lookup;
        logic        hit;
        logic [47:0] mac;    // answer MAC, or requester MAC for a reply
        logic [31:0] ip;     // requester IP for a reply
    } t_job;
endpackage

// ===== rtl/core/arprc_front.sv =====
// Front end: header capture, ARP check, cache learning and lookup answers.
module arprc_front import arprc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [31:0] i_lookup_ip,
    input  logic [31:0] i_local_ip,
    input  logic        i_space,
    output logic        o_push,
    output t_job        o_job
);
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_hdr [KEEP_FIRST:HDR_LEN-1];
    logic [7:0]       w_hv  [KEEP_FIRST:HDR_LEN-1];
    logic [47:0]      r_cache_mac;
    logic [31:0]      r_cache_ip;

    logic        w_acc, w_rx, w_full, w_arp, w_end, w_learn, w_reply;
    logic [47:0] w_sha;
    logic [31:0] w_spa, w_tpa;

    assign o_ready = i_space;
    assign w_acc   = i_valid && i_space;
    assign w_rx    = w_acc && (i_cmd == CMD_RX);

    // Header view including the byte now arriving (it may be the last one)
    always_comb begin
        for (int i = KEEP_FIRST; i < HDR_LEN; i++) begin
            w_hv[i] = r_hdr[i];
        end
        if (r_count == CNT_W'(HDR_LEN - 1)) begin
            w_hv[HDR_LEN-1] = i_byte;
        end
    end

    assign w_sha = {w_hv[22], w_hv[23], w_hv[24], w_hv[25], w_hv[26], w_hv[27]};
    assign w_spa = {w_hv[28], w_hv[29], w_hv[30], w_hv[31]};
    assign w_tpa = {w_hv[38], w_hv[39], w_hv[40], w_hv[41]};

    assign w_full = r_count >= CNT_W'(HDR_LEN - 1);
    assign w_arp  = ({w_hv[12], w_hv[13]} == ARP_ETHTYPE) &&
                    ({w_hv[14], w_hv[15]} == HTYPE_ETH) &&
                    ({w_hv[16], w_hv[17]} == PTYPE_IPV4) &&
                    (w_hv[18] == HLEN_ETH) && (w_hv[19] == PLEN_IPV4);
    assign w_end   = w_rx && i_last && w_full && w_arp;
    assign w_learn = w_end && (w_spa != 32'd0);
    assign w_reply = w_end && ({w_hv[20], w_hv[21]} == OPER_REQUEST) &&
                     (w_tpa == i_local_ip);

    assign o_push = (w_acc && (i_cmd == CMD_LOOKUP)) || w_reply;

    always_comb begin
        o_job = '0;
        if (i_cmd == CMD_LOOKUP) begin
            o_job.lookup = 1'b1;
            if (i_lookup_ip != IP_BCAST && i_lookup_ip == r_cache_ip) begin
                o_job.mac = r_cache_mac;
                o_job.hit = 1'b1;
            end else begin
                o_job.mac = MAC_BCAST;
            end
        end else begin
            o_job.mac = w_sha;
            o_job.ip  = w_spa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cache_mac <= '0;
            r_cache_ip  <= '0;
        end else begin
            if (w_rx) begin
                if (i_last) begin
                    r_count <= '0;
                end else if (r_count < CNT_W'(HDR_LEN)) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (w_learn) begin
                r_cache_mac <= w_sha;
                r_cache_ip  <= w_spa;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rx) begin
            for (int i = KEEP_FIRST; i < HDR_LEN; i++) begin
                if (r_count == CNT_W'(i)) begin
                    r_hdr[i] <= i_byte;
                end
            end
        end
    end
endmodule

// ===== rtl/core/arprc_queue.sv =====
// Job queue between the front end and the reply/answer back end.
`include "arp_responder_with_cache_defines.svh"
module arprc_queue import arprc_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_space,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_space = r_count != CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ARPRC_NEVER(a_push_full, i_clk, i_rst_n, i_push && !o_space, "push into full queue")
    `ARPRC_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && r_count == '0, "pop from empty queue")
    `ARPRC_ASSERT(a_count_up, i_clk, i_rst_n, i_push && !i_pop |=> r_count == $past(r_count) + 1'b1, "queue count lost a push")
    `ARPRC_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CW'(DEPTH), "queue count overflow")
endmodule

// ===== rtl/core/arprc_back.sv =====
// Back end: expands reply jobs into frame bytes, drives the output register.
`include "arp_responder_with_cache_defines.svh"
module arprc_back import arprc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    input  logic [47:0] i_local_mac,
    input  logic [31:0] i_local_ip,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [63:0] o_tdata,
    output logic        o_tlast,
    output logic        o_tuser
);
    logic [CNT_W-1:0]       r_idx;
    logic [CNT_W-1:0]       w_sel;
    logic [8*HDR_LEN-1:0]   w_rep;
    logic [7:0]             w_byte;
    logic                   w_load, w_lastbyte;

    logic        r_ovalid, r_kind, r_tlast, r_hit;
    logic [7:0]  r_txb;
    logic [47:0] r_mac;

    // Reply frame, byte 0 in the top bits
    assign w_rep = {i_job.mac, i_local_mac, ARP_ETHTYPE, HTYPE_ETH, PTYPE_IPV4,
                    HLEN_ETH, PLEN_IPV4, OPER_REPLY, i_local_mac, i_local_ip,
                    i_job.mac, i_job.ip};
    assign w_sel      = CNT_W'(HDR_LEN - 1) - r_idx;
    assign w_byte     = w_rep[{w_sel, 3'b000} +: 8];
    assign w_lastbyte = r_idx == CNT_W'(HDR_LEN - 1);

    assign w_load = i_valid && (!r_ovalid || i_tready);
    assign o_pop  = w_load && (i_job.lookup || w_lastbyte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_load && !i_job.lookup) begin
                r_idx <= w_lastbyte ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (i_job.lookup) begin
                r_kind  <= KIND_LOOKUP;
                r_txb   <= '0;
                r_tlast <= 1'b0;
                r_mac   <= i_job.mac;
                r_hit   <= i_job.hit;
            end else begin
                r_kind  <= KIND_BYTE;
                r_txb   <= w_byte;
                r_tlast <= w_lastbyte;
                r_mac   <= '0;
                r_hit   <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = {7'd0, r_hit, r_mac, r_txb};
    assign o_tlast  = r_tlast;
    assign o_tuser  = r_kind;

    `ARPRC_ASSERT(a_mid_reply, i_clk, i_rst_n, r_idx != '0 |-> i_valid && !i_job.lookup, "reply lost")
    `ARPRC_NEVER(a_lookup_last, i_clk, i_rst_n, r_ovalid && r_kind == KIND_LOOKUP && r_tlast, "bad tlast")
    `ARPRC_ASSERT(a_idx_range, i_clk, i_rst_n, r_idx <= CNT_W'(HDR_LEN - 1), "reply index out of range")
endmodule

// ===== rtl/core/arp_responder_with_cache.sv =====
// Top level of the ARP responder with a single-entry address cache.
// Input stream: s_axis_tuser selects a received frame byte (0) or a lookup (1).
//   Frame bytes come in wire order in tdata[7:0], tlast on the final byte;
//   lookups carry the IPv4 address in tdata[39:8].
// Output stream: m_axis_tuser 0 is a reply byte (tdata[7:0], tlast on byte 42),
//   1 is a lookup answer (MAC in tdata[55:8], hit flag in tdata[56]).
// Config: i_cfg_addr 0 writes local_mac, 1 writes local_ip, taken when i_cfg_we.
// One input transfer per cycle is taken while the job queue has room; frame
// checking, cache learning and lookups are resolved in the cycle of the transfer.
// A lookup answer or the first reply byte passes through the job queue and then
// the output register; a reply then streams 42 bytes at one per cycle while the
// receiver accepts them. The back end starts no new job before a reply's last byte.
// Reset clears the cache (IP 0, MAC 0), the config, the byte counter and queue.
// When the receiver stalls, the output holds, the queue fills and s_axis_tready
// drops once QUEUE_DEPTH jobs are waiting.
module arp_responder_with_cache import arprc_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // rx_byte[7:0], lookup_ip[39:8]
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // tx_byte[7:0], dest_mac[55:8], cache_hit[56]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // kind
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [47:0] i_cfg_data
);
    logic [47:0] r_local_mac;
    logic [31:0] r_local_ip;
    logic        w_push, w_space, w_qvalid, w_pop;
    t_job        w_push_job, w_head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_mac <= '0;
            r_local_ip  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LOCAL_MAC: r_local_mac <= i_cfg_data;
                CFG_LOCAL_IP:  r_local_ip  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    arprc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_byte      (s_axis_tdata[7:0]),
        .i_last      (s_axis_tlast),
        .i_lookup_ip (s_axis_tdata[39:8]),
        .i_local_ip  (r_local_ip),
        .i_space     (w_space),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    arprc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_space (w_space),
        .o_valid (w_qvalid),
        .o_job   (w_head_job),
        .i_pop   (w_pop)
    );

    arprc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_qvalid),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .i_local_mac (r_local_mac),
        .i_local_ip  (r_local_ip),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast),
        .o_tuser     (m_axis_tuser)
    );
endmodule
